>>> hdl/lpl_pkg.sv
`timescale 1ns / 1ps
// lpl_pkg: shared constants and controller/datapath handshake structs
// for the longest palindrome length block; no dependencies

package lpl_pkg;

	localparam int MAX_LEN_DEF = 4096;
	localparam int CHAR_W      = 8;
	localparam int LEN_W       = 13;

	typedef struct packed {
		logic load;        // store the incoming byte
		logic scan_start;  // set up the scan registers for a new string
		logic clamp;       // take mirrored radius clamped to the bound
		logic step;        // grow current radius by one
		logic char_rd;     // issue the two character reads
		logic commit;      // write radius, move centre and bound, next position
		logic result_load; // move best length into the output register
	} cmd_t;

	typedef struct packed {
		logic ext_stop;    // extension has reached an edge
		logic hi_odd;      // next extension step compares two characters
		logic chars_equal; // registered characters match
		logic last_pos;    // current position is the last one
		logic out_free;    // output register can take a new result
	} status_t;

endpackage

>>> hdl/lpl_ctrl.sv
`timescale 1ns / 1ps
// lpl_ctrl: sequencer for byte loading and the radius scan
// depends on lpl_pkg

module lpl_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              char_valid,
	input  logic              last,
	output logic              char_stall,
	input  lpl_pkg::status_t  status,
	output lpl_pkg::cmd_t     cmd
);

	localparam logic [2:0] ST_LOAD   = 3'd0;
	localparam logic [2:0] ST_MIRROR = 3'd1;
	localparam logic [2:0] ST_CLAMP  = 3'd2;
	localparam logic [2:0] ST_CHECK  = 3'd3;
	localparam logic [2:0] ST_CMP    = 3'd4;
	localparam logic [2:0] ST_UPDATE = 3'd5;
	localparam logic [2:0] ST_RESULT = 3'd6;

	logic [2:0] state_q;
	logic [2:0] state_d;

	assign char_stall = (state_q != ST_LOAD);

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		unique case (state_q)
			ST_LOAD: begin
				if (char_valid) begin
					cmd.load = 1'b1;
					if (last) begin
						cmd.scan_start = 1'b1;
						state_d        = ST_MIRROR;
					end
				end
			end
			ST_MIRROR: begin
				state_d = ST_CLAMP;
			end
			ST_CLAMP: begin
				cmd.clamp = 1'b1;
				state_d   = ST_CHECK;
			end
			ST_CHECK: begin
				priority if (status.ext_stop) begin
					state_d = ST_UPDATE;
				end else if (status.hi_odd) begin
					cmd.char_rd = 1'b1;
					state_d     = ST_CMP;
				end else begin
					cmd.step = 1'b1;
				end
			end
			ST_CMP: begin
				if (status.chars_equal) begin
					cmd.step = 1'b1;
					state_d  = ST_CHECK;
				end else begin
					state_d = ST_UPDATE;
				end
			end
			ST_UPDATE: begin
				cmd.commit = 1'b1;
				state_d    = status.last_pos ? ST_RESULT : ST_MIRROR;
			end
			ST_RESULT: begin
				if (status.out_free) begin
					cmd.result_load = 1'b1;
					state_d         = ST_LOAD;
				end
			end
			default: begin
				state_d = ST_LOAD;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_LOAD;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

>>> hdl/lpl_dp.sv
`timescale 1ns / 1ps
// lpl_dp: character and radius memories, scan registers and output register
// depends on lpl_pkg

module lpl_dp #(
	parameter int MAX_LEN = lpl_pkg::MAX_LEN_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic [lpl_pkg::CHAR_W-1:0]  character,
	input  lpl_pkg::cmd_t               cmd,
	output lpl_pkg::status_t            status,
	input  logic                        result_stall,
	output logic                        result_valid,
	output logic [lpl_pkg::LEN_W-1:0]   longest_length,
	output logic                        overflow
);

	localparam int CW     = $clog2(MAX_LEN + 1);
	localparam int PW     = CW + 1;
	localparam int AW     = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
	localparam int RDEPTH = 2 * MAX_LEN + 1;
	localparam int RAW    = $clog2(RDEPTH);

	logic [lpl_pkg::CHAR_W-1:0] char_mem [MAX_LEN];
	logic [CW-1:0]              rad_mem  [RDEPTH];

	logic [CW-1:0] count_q;
	logic          ovf_q;
	logic [PW-1:0] span_q;
	logic [PW-1:0] pos_q;
	logic [PW-1:0] centre_q;
	logic [PW-1:0] bound_q;
	logic [CW-1:0] best_q;
	logic [CW-1:0] k_q;
	logic [CW-1:0] rad_rd_q;
	logic [lpl_pkg::CHAR_W-1:0] char_a_q;
	logic [lpl_pkg::CHAR_W-1:0] char_b_q;
	logic                       res_valid_q;
	logic [lpl_pkg::LEN_W-1:0]  res_len_q;
	logic                       res_ovf_q;

	logic          has_room;
	logic [CW-1:0] count_next;
	logic [PW:0]   hi;
	logic [PW:0]   pos_plus_k;
	logic [PW-1:0] pos_minus;
	logic [PW:0]   mirror;
	logic [PW-1:0] room;
	logic [PW-1:0] rad_sel;
	logic [PW-1:0] k_clamped;
	logic [PW-1:0] k_ext;
	logic [PW-1:0] reach;
	logic [PW:0]   pos_next;
	logic [CW+lpl_pkg::LEN_W-1:0] best_ext;

	assign has_room   = (count_q < CW'(MAX_LEN));
	assign count_next = has_room ? count_q + CW'(1) : count_q;

	assign k_ext      = {1'b0, k_q};
	assign pos_plus_k = {1'b0, pos_q} + {1'b0, k_ext};
	assign hi         = pos_plus_k + (PW+1)'(1);
	assign pos_minus  = pos_q - k_ext - PW'(2);
	assign mirror     = {centre_q, 1'b0} - {1'b0, pos_q};
	assign room       = bound_q - pos_q;
	assign reach      = pos_plus_k[PW-1:0];
	assign pos_next   = {1'b0, pos_q} + (PW+1)'(1);

	always_comb begin
		priority if (mirror == (PW+1)'(0)) begin
			rad_sel = '0;
		end else if (mirror == (PW+1)'(1)) begin
			rad_sel = PW'(1);
		end else begin
			rad_sel = {1'b0, rad_rd_q};
		end
		if (pos_q < bound_q) begin
			k_clamped = (rad_sel > room) ? room : rad_sel;
		end else begin
			k_clamped = '0;
		end
	end

	assign status.ext_stop    = (hi >= {1'b0, span_q}) || (pos_q < k_ext + PW'(1));
	assign status.hi_odd      = hi[0];
	assign status.chars_equal = (char_a_q == char_b_q);
	assign status.last_pos    = (pos_next == {1'b0, span_q});
	assign status.out_free    = !res_valid_q || !result_stall;

	// memories
	always_ff @(posedge clk) begin
		if (cmd.load && has_room) begin
			char_mem[count_q[AW-1:0]] <= character;
		end
		if (cmd.char_rd) begin
			char_a_q <= char_mem[pos_plus_k[AW:1]];
			char_b_q <= char_mem[pos_minus[AW:1]];
		end
		if (cmd.commit) begin
			rad_mem[pos_q[RAW-1:0]] <= k_q;
		end
		rad_rd_q <= rad_mem[mirror[RAW-1:0]];
	end

	// scan registers
	always_ff @(posedge clk) begin
		if (cmd.scan_start) begin
			span_q   <= {count_next, 1'b1};
			pos_q    <= PW'(2);
			centre_q <= PW'(1);
			bound_q  <= PW'(2);
			best_q   <= CW'(1);
		end else if (cmd.commit) begin
			if (reach > bound_q) begin
				centre_q <= pos_q;
				bound_q  <= reach;
			end
			if (k_q > best_q) begin
				best_q <= k_q;
			end
			pos_q <= pos_next[PW-1:0];
		end
		if (cmd.clamp) begin
			k_q <= k_clamped[CW-1:0];
		end else if (cmd.step) begin
			k_q <= k_q + CW'(1);
		end
	end

	// byte count and overflow
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			ovf_q   <= 1'b0;
		end else if (cmd.result_load) begin
			count_q <= '0;
			ovf_q   <= 1'b0;
		end else if (cmd.load) begin
			count_q <= count_next;
			if (!has_room) begin
				ovf_q <= 1'b1;
			end
		end
	end

	assign best_ext = {{lpl_pkg::LEN_W{1'b0}}, best_q};

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (cmd.result_load) begin
			res_valid_q <= 1'b1;
		end else if (!result_stall) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.result_load) begin
			res_len_q <= best_ext[lpl_pkg::LEN_W-1:0];
			res_ovf_q <= ovf_q;
		end
	end

	assign result_valid   = res_valid_q;
	assign longest_length = res_len_q;
	assign overflow       = res_ovf_q;

endmodule

>>> hdl/longest_palindrome_length.sv
`timescale 1ns / 1ps
// Bytes of a string arrive one per cycle and are stored until the byte marked
// last; a scan over the 2n+1 interleaved positions then finds the longest
// palindromic substring and one result transaction gives its length and
// whether bytes beyond MAX_LEN were dropped. During the scan the input is
// stalled: for each position the sequencer reads the mirrored radius, clamps
// it to the bound, then extends the radius one step at a time, comparing two
// characters through the registered character memory reads where a step needs
// it, and finally commits the radius. A finished result waits in an output
// register while the next string loads. Depends on lpl_pkg, lpl_ctrl, lpl_dp.

module longest_palindrome_length #(
	parameter int MAX_LEN = lpl_pkg::MAX_LEN_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        char_valid,
	output logic                        char_stall,
	input  logic [lpl_pkg::CHAR_W-1:0]  character,
	input  logic                        last,
	output logic                        result_valid,
	input  logic                        result_stall,
	output logic [lpl_pkg::LEN_W-1:0]   longest_length,
	output logic                        overflow
);

	lpl_pkg::cmd_t    cmd;
	lpl_pkg::status_t status;

	lpl_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.char_valid (char_valid),
		.last       (last),
		.char_stall (char_stall),
		.status     (status),
		.cmd        (cmd)
	);

	lpl_dp #(
		.MAX_LEN (MAX_LEN)
	) u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.character      (character),
		.cmd            (cmd),
		.status         (status),
		.result_stall   (result_stall),
		.result_valid   (result_valid),
		.longest_length (longest_length),
		.overflow       (overflow)
	);

endmodule

>>> tb/longest_palindrome_length_checker.sv
`timescale 1ns / 1ps
// longest_palindrome_length_checker: watches both channels, works out the longest
// palindrome length of every finished string and compares each result transaction.
// Depends on lpl_pkg.

module longest_palindrome_length_checker #(
	parameter int MAX_LEN = lpl_pkg::MAX_LEN_DEF
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       char_valid,
	input  logic                       char_stall,
	input  logic [lpl_pkg::CHAR_W-1:0] character,
	input  logic                       last,
	input  logic                       result_valid,
	input  logic                       result_stall,
	input  logic [lpl_pkg::LEN_W-1:0]  longest_length,
	input  logic                       overflow,
	output int                         results_pending,
	output int                         error_count
);

	typedef struct packed {
		logic [lpl_pkg::LEN_W-1:0] len;
		logic                      dropped;
	} palindrome_t;

	palindrome_t                   expected_results[$];
	logic [lpl_pkg::CHAR_W-1:0]    string_bytes [MAX_LEN];
	int unsigned                   radius [2*MAX_LEN+1];
	int unsigned                   bytes_stored;
	logic                          bytes_dropped;
	int                            errors;
	int                            pending;

	assign error_count     = errors;
	assign results_pending = pending;

	// radius per interleaved position, reusing mirrored radii inside the right bound
	function automatic int unsigned longest_palindrome(input int unsigned n);
		int unsigned span, p, k, hi, mirror, room, centre, reach, best;
		span = 2 * n + 1;
		radius[0] = 0;
		radius[1] = 1;
		centre = 1;
		reach = 2;
		best = 1;
		for (p = 2; p < span; p++) begin
			k = 0;
			if (p < reach) begin
				mirror = 2 * centre - p;
				room = reach - p;
				k = radius[mirror];
				if (k > room)
					k = room;
			end
			forever begin
				hi = p + k + 1;
				if (hi >= span || p < k + 1)
					break;
				if (hi[0] && string_bytes[(p + k) / 2] != string_bytes[(p - k - 2) / 2])
					break;
				k++;
			end
			radius[p] = k;
			if (p + k > reach) begin
				centre = p;
				reach = p + k;
			end
			if (k > best)
				best = k;
		end
		return best;
	endfunction

	always @(posedge clk or negedge arst_n) begin : monitor
		palindrome_t want;
		if (!arst_n) begin
			expected_results.delete();
			bytes_stored = 0;
			bytes_dropped = 1'b0;
			errors = 0;
			pending = 0;
		end else begin
			if (char_valid && !char_stall) begin
				if (bytes_stored < MAX_LEN) begin
					string_bytes[bytes_stored] = character;
					bytes_stored++;
				end else begin
					bytes_dropped = 1'b1;
				end
				if (last) begin
					want.len = lpl_pkg::LEN_W'(longest_palindrome(bytes_stored));
					want.dropped = bytes_dropped;
					expected_results = {expected_results, want};
					bytes_stored = 0;
					bytes_dropped = 1'b0;
				end
			end
			if (result_valid && !result_stall) begin
				if (expected_results.size() == 0) begin
					$error("unexpected result transaction: longest_length %0d, overflow %0d",
						longest_length, overflow);
					errors++;
				end else begin
					want = expected_results.pop_front();
					if (longest_length !== want.len) begin
						$error("longest_length mismatch: expected %0d, actual %0d",
							want.len, longest_length);
						errors++;
					end
					if (overflow !== want.dropped) begin
						$error("overflow mismatch: expected %0d, actual %0d",
							want.dropped, overflow);
						errors++;
					end
				end
			end
			pending = expected_results.size();
		end
	end

endmodule

>>> tb/longest_palindrome_length_tb.sv
`timescale 1ns / 1ps
// longest_palindrome_length_tb: drives strings into the block with random gaps and
// output stalls, and reports the checker's verdict. Depends on lpl_pkg, the block
// and longest_palindrome_length_checker.

module longest_palindrome_length_tb;

	localparam int STRING_MAX     = lpl_pkg::MAX_LEN_DEF;
	localparam int IDLE_LIMIT     = 20000;
	localparam int LONG_RUN       = 120;
	localparam int RANDOM_ITEMS   = 560;
	localparam int RANDOM_STRINGS = 30;
	localparam int DRAIN_CYCLES   = 50;

	typedef enum int {
		TEXT_NOISE,
		TEXT_LETTERS,
		TEXT_MIRROR,
		TEXT_EMBEDDED
	} text_style_t;

	logic                       clk;
	logic                       arst_n;
	logic                       char_valid;
	logic                       char_stall;
	logic [lpl_pkg::CHAR_W-1:0] character;
	logic                       last;
	logic                       result_valid;
	logic                       result_stall;
	logic [lpl_pkg::LEN_W-1:0]  longest_length;
	logic                       overflow;
	int                         results_pending;
	int                         error_count;

	logic [lpl_pkg::CHAR_W-1:0] text[$];
	bit                         sender_quiet;

	longest_palindrome_length #(.MAX_LEN(STRING_MAX)) DUT (
		.clk            (clk),
		.arst_n         (arst_n),
		.char_valid     (char_valid),
		.char_stall     (char_stall),
		.character      (character),
		.last           (last),
		.result_valid   (result_valid),
		.result_stall   (result_stall),
		.longest_length (longest_length),
		.overflow       (overflow)
	);

	longest_palindrome_length_checker #(.MAX_LEN(STRING_MAX)) result_check (
		.clk             (clk),
		.arst_n          (arst_n),
		.char_valid      (char_valid),
		.char_stall      (char_stall),
		.character       (character),
		.last            (last),
		.result_valid    (result_valid),
		.result_stall    (result_stall),
		.longest_length  (longest_length),
		.overflow        (overflow),
		.results_pending (results_pending),
		.error_count     (error_count)
	);

	initial clk = 1'b0;
	always #5 clk = ~clk;

	function automatic int draw_wait(input bit quiet);
		return quiet ? 0 : $urandom_range(0, 8);
	endfunction

	task automatic make_text(input int n, input text_style_t style);
		int i, seg, start, letters;
		text.delete();
		letters = $urandom_range(2, 4);
		for (i = 0; i < n; i++) begin
			if (style == TEXT_NOISE || style == TEXT_MIRROR)
				text = {text, 8'($urandom_range(0, 255))};
			else
				text = {text, 8'(8'h61 + $urandom_range(0, letters - 1))};
		end
		if (style == TEXT_MIRROR)
			for (i = 0; i < n / 2; i++)
				text[n - 1 - i] = text[i];
		if (style == TEXT_EMBEDDED) begin
			seg = $urandom_range(1, n);
			start = $urandom_range(0, n - seg);
			for (i = 0; i < seg / 2; i++)
				text[start + seg - 1 - i] = text[start + i];
		end
	endtask

	// one input transaction per byte, last on the final one
	task automatic send_text();
		int i, gap;
		for (i = 0; i < text.size(); i++) begin
			gap = draw_wait(sender_quiet);
			if (gap > 0) begin
				char_valid = 1'b0;
				repeat (gap) @(negedge clk);
			end
			char_valid = 1'b1;
			character = text[i];
			last = (i == text.size() - 1);
			@(posedge clk);
			while (char_stall)
				@(posedge clk);
			@(negedge clk);
		end
	endtask

	initial begin : stimulus
		int len, random_items, random_strings;
		char_valid = 1'b0;
		character = '0;
		last = 1'b0;
		arst_n = 1'b0;
		sender_quiet = 1'b0;
		random_items = 0;
		random_strings = 0;
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		text = '{8'h00};
		send_text();
		text = '{8'hFF};
		send_text();
		text = '{8'h41, 8'h41};
		send_text();
		text = '{8'h41, 8'h42};
		send_text();
		text = '{8'h55, 8'hAA, 8'h55};
		send_text();
		text = '{8'h61, 8'h62, 8'h62, 8'h61, 8'h63};
		send_text();
		text = '{8'hAA, 8'h00, 8'hFF, 8'h00, 8'hAA, 8'h55};
		send_text();

		// long run of one byte
		text.delete();
		repeat (LONG_RUN) text = {text, 8'h7E};
		sender_quiet = 1'b1;
		send_text();

		while (random_items < RANDOM_ITEMS || random_strings < RANDOM_STRINGS) begin
			len = ($urandom_range(0, 6) == 0) ? $urandom_range(17, 120) : $urandom_range(1, 16);
			make_text(len, text_style_t'($urandom_range(0, 3)));
			sender_quiet = ($urandom_range(0, 3) == 0);
			send_text();
			random_items += len;
			random_strings++;
		end
		char_valid = 1'b0;

		while (results_pending != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (error_count == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

	initial begin : result_drain
		int hold;
		result_stall = 1'b0;
		wait (arst_n === 1'b1);
		@(negedge clk);
		forever begin
			hold = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 8);
			if (hold > 0) begin
				result_stall = 1'b1;
				repeat (hold) @(negedge clk);
			end
			result_stall = 1'b0;
			@(posedge clk);
			while (!result_valid)
				@(posedge clk);
			@(negedge clk);
		end
	end

	initial begin : watchdog
		int idle_cycles;
		idle_cycles = 0;
		while (idle_cycles < IDLE_LIMIT) begin
			@(posedge clk);
			if ((char_valid && !char_stall) || (result_valid && !result_stall))
				idle_cycles = 0;
			else
				idle_cycles++;
		end
		$display("Verification failed");
		$finish;
	end

endmodule
